[rtl/trws_pkg.sv]
// Shared types and constants for the text region with line wrap and scroll.
// Holds the item structs, command codes and the controller/datapath links.
// Depends on nothing; every other file of the block but trws_ram imports it.
package trws_pkg;

  // Field widths of the items and of the configuration registers
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int RROW_W    = 6;
  localparam int RCOL_W    = 7;
  localparam int LINE_W    = 6;
  localparam int CURCOL_W  = 8;
  localparam int COL_CFG_W = 8;
  localparam int ROW_CFG_W = 7;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;

  localparam logic [COL_CFG_W-1:0] COLUMN_COUNT_RESET = 8'd80;
  localparam logic [ROW_CFG_W-1:0] ROW_COUNT_RESET    = 7'd24;

  // Default geometry of the cell store
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_COLUMN_COUNT = 1'b0,
    REG_ROW_COUNT    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [LINE_W-1:0]   cursor_line;
    logic [CURCOL_W-1:0] cursor_column;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic norm_step;
    logic clr_step;
    logic clr_done;
    logic next_line;
    logic blank_step;
    logic write_char;
    logic read_en;
    logic cap_cell;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_t cmd;
    logic dirty;
    logic is_newline;
    logic col_full;
    logic wrap;
    logic norm_last;
    logic row_last;
    logic sweep_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[rtl/text_region_wrap_scroll.sv]
// Top level of the text region with line wrap and scroll: configuration
// registers on an APB-style port, controller and datapath instances.
// Depends on trws_pkg, trws_ctrl, trws_dp and trws_ram.
//
// A window of row_count rows by column_count columns of byte cells, stored
// as a ring of rows so that a scroll moves the top offset and blanks a single
// row. Each item is a clear, put-character or read-cell command and gives one
// result item (command code 3 is taken and gives none). A put writes through
// the single write port of the cell store and a read uses its registered read
// port. A scroll blanks every stored cell of the new bottom row, one cell a
// cycle. A clear writes space to every cell one at a time; it must be issued
// before the window is used, as the store has no reset. After a write to
// row_count, the next put or read first reduces the top row offset modulo the
// new row count.
module text_region_wrap_scroll #(
  parameter int MAX_COLUMNS = trws_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = trws_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  trws_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output trws_pkg::out_item_t            result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trws_pkg::PADDR_W-1:0]   paddr,
  input  logic [trws_pkg::PDATA_W-1:0]   pwdata,
  output logic [trws_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import trws_pkg::*;

  logic [COL_CFG_W-1:0] column_count;
  logic [ROW_CFG_W-1:0] row_count;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 rows_written;
  ctl_cmd_t             ctl;
  dp_sts_t              sts;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_idx      = reg_idx_t'(paddr[REG_IDX_LSB]);
  assign rows_written = cfg_wr && (cfg_idx == REG_ROW_COUNT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLUMN_COUNT_RESET;
      row_count    <= ROW_COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COLUMN_COUNT: column_count <= pwdata[COL_CFG_W-1:0];
        REG_ROW_COUNT:    row_count    <= pwdata[ROW_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_COLUMN_COUNT: prdata = PDATA_W'(column_count);
      REG_ROW_COUNT:    prdata = PDATA_W'(row_count);
      default:          prdata = '0;
    endcase
  end

  trws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  trws_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .column_count (column_count),
    .row_count    (row_count),
    .rows_written (rows_written),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/trws_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the character cell store; depends on nothing.
module trws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/trws_ctrl.sv]
// Sequencing state machine for the text region: steps each item through
// clear sweep, offset reduction, row blanking, cursor moves, cell write or cell read.
// Depends on trws_pkg; drives the datapath through ctl_cmd_t only.
module trws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  trws_pkg::dp_sts_t  sts,
  output trws_pkg::ctl_cmd_t ctl
);

  import trws_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_NORM,
    S_CLEAR,
    S_NEXTLINE,
    S_BLANK,
    S_WRITE,
    S_READ,
    S_READ_DATA,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    ctl        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_CLEAR: state_next = S_CLEAR;
          CMD_PUT: begin
            if (sts.dirty) begin
              state_next = S_NORM;
            end else if (sts.is_newline || sts.col_full) begin
              state_next = S_NEXTLINE;
            end else begin
              state_next = S_WRITE;
            end
          end
          CMD_READ: state_next = sts.dirty ? S_NORM : S_READ;
          default:  state_next = S_IDLE;
        endcase
      end
      S_NORM: begin
        ctl.norm_step = 1'b1;
        if (sts.norm_last) begin
          state_next = S_DISPATCH;
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.sweep_last) begin
          ctl.clr_done = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_NEXTLINE: begin
        ctl.next_line = 1'b1;
        if (sts.wrap) begin
          state_next = S_BLANK;
        end else begin
          state_next = sts.is_newline ? S_FINISH : S_WRITE;
        end
      end
      S_BLANK: begin
        ctl.blank_step = 1'b1;
        if (sts.row_last) begin
          state_next = sts.is_newline ? S_FINISH : S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.write_char = 1'b1;
        state_next     = S_FINISH;
      end
      S_READ: begin
        ctl.read_en = 1'b1;
        state_next  = S_READ_DATA;
      end
      S_READ_DATA: begin
        ctl.cap_cell = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is only loaded once the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> !sts.out_busy)
    else $error("result loaded over a waiting result");

  // An item is only taken when no earlier item is still at work
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second item taken while busy");

  // A clear sweep ends in the result stage
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_done |=> state == S_FINISH)
    else $error("clear sweep did not finish");

endmodule

[rtl/trws_dp.sv]
// Datapath of the text region: cursor and scroll registers, ring row
// mapping, offset reduction unit, sweep counter, cell store and result item.
// Depends on trws_pkg and trws_ram.
module trws_dp #(
  parameter int MAX_COLUMNS = trws_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = trws_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  trws_pkg::in_item_t                 item,
  input  logic [trws_pkg::COL_CFG_W-1:0]     column_count,
  input  logic [trws_pkg::ROW_CFG_W-1:0]     row_count,
  input  logic                               rows_written,
  input  trws_pkg::ctl_cmd_t                 ctl,
  output trws_pkg::dp_sts_t                  sts,
  output logic                               result_valid,
  input  logic                               result_ready,
  output trws_pkg::out_item_t                result
);

  import trws_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int AW  = RW + CW;
  localparam int NCW = (RW > 1) ? $clog2(RW) : 1;

  // Control state
  logic [RW-1:0]       top_raw;
  logic [RW-1:0]       top_mod;
  logic [RW-1:0]       cur_row;
  logic [CURCOL_W-1:0] cur_col;
  logic                dirty;

  // Item payload and working registers
  cmd_t              in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic [RROW_W-1:0] in_rrow;
  logic [RCOL_W-1:0] in_rcol;
  logic [CHAR_W-1:0] cell_byte;
  logic [AW-1:0]     sweep;
  logic [RW-1:0]     blank_prow;
  logic [RW-1:0]     div_q;
  logic [RNW-1:0]    rem;
  logic [NCW-1:0]    norm_cnt;

  // Combinational values
  logic [COL_CFG_W-1:0] cols;
  logic [RNW-1:0]       rows;
  logic [RNW-1:0]       rows_m1;
  logic [RW-1:0]        shown;
  logic [RW:0]          row_sum;
  logic [RW-1:0]        prow;
  logic [RW:0]          top_inc;
  logic [RW-1:0]        top_step;
  logic [RNW:0]         r_sh;
  logic [RNW:0]         r_sub;
  logic                 wrap;
  logic                 oob;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CHAR_W-1:0]    ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CHAR_W-1:0]    ram_rdata;

  // Clamp the register values to the store geometry
  always_comb begin
    if (column_count == '0) begin
      cols = COL_CFG_W'(1);
    end else if ({1'b0, column_count} > (COL_CFG_W + 1)'(MAX_COLUMNS)) begin
      cols = COL_CFG_W'(MAX_COLUMNS);
    end else begin
      cols = column_count;
    end
    if (row_count == '0) begin
      rows = RNW'(1);
    end else if ({1'b0, row_count} > (ROW_CFG_W + 1)'(MAX_ROWS)) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(row_count);
    end
    rows_m1 = rows - RNW'(1);
  end

  // Map a displayed row onto the ring of stored rows
  always_comb begin
    shown   = (in_cmd == CMD_READ) ? RW'(in_rrow) : cur_row;
    row_sum = {1'b0, top_mod} + {1'b0, shown};
    if (row_sum >= (RW + 1)'(rows)) begin
      prow = RW'(row_sum - (RW + 1)'(rows));
    end else begin
      prow = RW'(row_sum);
    end
    top_inc  = {1'b0, top_mod} + (RW + 1)'(1);
    top_step = (top_inc >= (RW + 1)'(rows)) ? '0 : RW'(top_inc);
    wrap     = ((RNW + 1)'(cur_row) + (RNW + 1)'(1)) >= (RNW + 1)'(rows);
    oob      = (8'(in_rrow) >= 8'(rows)) || ({1'b0, in_rcol} >= cols);
  end

  // One restoring step of the top offset reduction
  always_comb begin
    r_sh = {rem, div_q[RW-1]};
    if (r_sh >= (RNW + 1)'(rows)) begin
      r_sub = r_sh - (RNW + 1)'(rows);
    end else begin
      r_sub = r_sh;
    end
  end

  // Cell store ports
  always_comb begin
    ram_we = ctl.clr_step || ctl.blank_step || ctl.write_char;
    if (ctl.clr_step) begin
      ram_waddr = sweep;
    end else if (ctl.blank_step) begin
      ram_waddr = {blank_prow, sweep[CW-1:0]};
    end else begin
      ram_waddr = {prow, CW'(cur_col)};
    end
    ram_wdata = ctl.write_char ? in_char : CODE_SPACE;
    ram_raddr = {prow, CW'(in_rcol)};
  end

  trws_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (2 ** AW)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.read_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  always_comb begin
    sts.cmd        = in_cmd;
    sts.dirty      = dirty;
    sts.is_newline = (in_char == CODE_NEWLINE);
    sts.col_full   = (cur_col >= cols);
    sts.wrap       = wrap;
    sts.norm_last  = (norm_cnt == NCW'(RW - 1));
    sts.row_last   = &sweep[CW-1:0];
    sts.sweep_last = &sweep;
    sts.out_busy   = result_valid && !result_ready;
  end

  // Cursor, scroll offset and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      top_raw      <= '0;
      top_mod      <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      dirty        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rows_written) begin
        dirty <= 1'b1;
      end
      // Saturate the cursor to the window before a put
      if (ctl.load_in && (item.command == CMD_PUT)) begin
        if (RNW'(cur_row) >= rows) begin
          cur_row <= RW'(rows_m1);
        end
        if (cur_col > cols) begin
          cur_col <= cols;
        end
      end
      if (ctl.norm_step && sts.norm_last) begin
        top_mod <= RW'(r_sub);
        dirty   <= 1'b0;
      end
      // Advance the line, scrolling when it passes the last row
      if (ctl.next_line) begin
        cur_col <= '0;
        if (wrap) begin
          top_raw <= top_step;
          top_mod <= top_step;
          cur_row <= RW'(rows_m1);
        end else begin
          cur_row <= cur_row + RW'(1);
        end
      end
      if (ctl.write_char) begin
        cur_col <= cur_col + CURCOL_W'(1);
      end
      if (ctl.clr_done) begin
        top_raw <= '0;
        top_mod <= '0;
        cur_row <= '0;
        cur_col <= '0;
        dirty   <= 1'b0;
      end
      if (ctl.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Item payload, sweep counter and reduction registers
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_cmd    <= cmd_t'(item.command);
      in_char   <= item.char_code;
      in_rrow   <= item.read_row;
      in_rcol   <= item.read_col;
      cell_byte <= '0;
      sweep     <= '0;
      div_q     <= top_raw;
      rem       <= '0;
      norm_cnt  <= '0;
    end
    if (ctl.norm_step) begin
      rem      <= RNW'(r_sub);
      div_q    <= div_q << 1;
      norm_cnt <= norm_cnt + NCW'(1);
    end
    if (ctl.clr_step || ctl.blank_step) begin
      sweep <= sweep + AW'(1);
    end
    if (ctl.next_line && wrap) begin
      blank_prow <= top_mod;
    end
    if (ctl.cap_cell) begin
      cell_byte <= oob ? CODE_SPACE : ram_rdata;
    end
    if (ctl.load_out) begin
      result.cell_char     <= cell_byte;
      result.cursor_line   <= LINE_W'(cur_row);
      result.cursor_column <= cur_col;
    end
  end

  // The cursor column never passes the widest row
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (CURCOL_W + 1)'(cur_col) <= (CURCOL_W + 1)'(MAX_COLUMNS))
    else $error("cursor column beyond store width");

  // A character is only written inside the row in use
  a_write_in_row: assert property (@(posedge clk) disable iff (rst)
    ctl.write_char |-> (cur_col < cols))
    else $error("character written past the row end");

  // The reduced offset lies inside the window
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.norm_step && sts.norm_last) |=> (RNW'(top_mod) < rows))
    else $error("top offset reduction out of range");

  // The store is never written and read in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ctl.read_en))
    else $error("cell store written during a read");

endmodule

[bench/tb_text_region_wrap_scroll.sv]
// Self-checking bench for text_region_wrap_scroll: clear, put and read items
// against a cycle-free model of the text window, under several window sizes.
// Depends on trws_pkg and the RTL of the block; needs no files or arguments.
module tb_text_region_wrap_scroll;
  import trws_pkg::*;

  localparam int MAX_COLS     = DEF_MAX_COLUMNS;
  localparam int MAX_LINES    = DEF_MAX_ROWS;
  localparam int CELL_COUNT   = MAX_COLS * MAX_LINES;
  localparam int IDLE_PCT     = 26;
  localparam int DRAIN_CYCLES = 2 ** $clog2(MAX_COLS) + 16;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int PRINT_CAP    = 40;

  // Model of the window: ring of rows, cursor, registers, replies in flight
  class text_window_tracker;
    logic [CHAR_W-1:0]    cells [CELL_COUNT];
    int unsigned          top_offset;
    int unsigned          cur_row;
    int unsigned          cur_col;
    logic [COL_CFG_W-1:0] column_count;
    logic [ROW_CFG_W-1:0] row_count;
    out_item_t            window_replies [$];
    int unsigned          fail_count;
    int unsigned          checked_count;
    int unsigned          scroll_count;
    int unsigned          wrap_count;
    int unsigned          clear_count;

    function new();
      foreach (cells[i]) cells[i] = '0;
      top_offset    = 0;
      cur_row       = 0;
      cur_col       = 0;
      column_count  = COLUMN_COUNT_RESET;
      row_count     = ROW_COUNT_RESET;
      fail_count    = 0;
      checked_count = 0;
      scroll_count  = 0;
      wrap_count    = 0;
      clear_count   = 0;
    endfunction

    task report(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    function int unsigned cols_in_use();
      if (column_count == 0) return 1;
      if (column_count > MAX_COLS) return MAX_COLS;
      return 32'(column_count);
    endfunction

    function int unsigned rows_in_use();
      if (row_count == 0) return 1;
      if (row_count > MAX_LINES) return MAX_LINES;
      return 32'(row_count);
    endfunction

    function void write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
      if (idx == REG_COLUMN_COUNT) begin
        column_count = value[COL_CFG_W-1:0];
      end else begin
        row_count = value[ROW_CFG_W-1:0];
      end
    endfunction

    // Map a displayed row onto the ring
    function int unsigned store_row(int unsigned shown, int unsigned rows);
      return ((top_offset % rows) + shown) % rows;
    endfunction

    // Go to the start of the next line; scroll and blank the bottom row past the end
    function void advance_line(int unsigned rows);
      int unsigned prow;
      cur_col = 0;
      cur_row++;
      if (cur_row >= rows) begin
        top_offset = ((top_offset % rows) + 1) % rows;
        cur_row    = rows - 1;
        prow       = store_row(rows - 1, rows);
        for (int c = 0; c < MAX_COLS; c++) cells[prow * MAX_COLS + c] = CODE_SPACE;
        scroll_count++;
      end
    endfunction

    function void apply_put(logic [CHAR_W-1:0] code);
      int unsigned cols;
      int unsigned rows;
      cols = cols_in_use();
      rows = rows_in_use();
      // Pull the cursor back inside a window that has shrunk
      if (cur_row >= rows) cur_row = rows - 1;
      if (cur_col > cols) cur_col = cols;
      if (code == CODE_NEWLINE) begin
        advance_line(rows);
        return;
      end
      if (cur_col >= cols) begin
        advance_line(rows);
        wrap_count++;
      end
      cells[store_row(cur_row, rows) * MAX_COLS + cur_col] = code;
      cur_col++;
    endfunction

    function void note_item(in_item_t it);
      out_item_t   reply;
      int unsigned cols;
      int unsigned rows;
      reply = '0;
      cols  = cols_in_use();
      rows  = rows_in_use();
      case (cmd_t'(it.command))
        CMD_NONE: return;
        CMD_CLEAR: begin
          foreach (cells[i]) cells[i] = CODE_SPACE;
          top_offset = 0;
          cur_row    = 0;
          cur_col    = 0;
          clear_count++;
        end
        CMD_PUT: apply_put(it.char_code);
        CMD_READ: begin
          if (it.read_row >= rows || it.read_col >= cols) begin
            reply.cell_char = CODE_SPACE;
          end else begin
            reply.cell_char = cells[store_row(it.read_row, rows) * MAX_COLS + it.read_col];
          end
        end
        default: return;
      endcase
      reply.cursor_line   = cur_row[LINE_W-1:0];
      reply.cursor_column = cur_col[CURCOL_W-1:0];
      window_replies.push_back(reply);
    endfunction

    task check_result(input out_item_t got);
      out_item_t want;
      if (window_replies.size() == 0) begin
        report($sformatf("result %h arrived with no item waiting", got));
        return;
      end
      want = window_replies.pop_front();
      checked_count++;
      if (got.cell_char !== want.cell_char)
        report($sformatf("result %0d cell_char %h, want %h",
                         checked_count, got.cell_char, want.cell_char));
      if (got.cursor_line !== want.cursor_line)
        report($sformatf("result %0d cursor_line %0d, want %0d",
                         checked_count, got.cursor_line, want.cursor_line));
      if (got.cursor_column !== want.cursor_column)
        report($sformatf("result %0d cursor_column %0d, want %0d",
                         checked_count, got.cursor_column, want.cursor_column));
    endtask
  endclass

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  in_item_t             item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  out_item_t            result;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [PADDR_W-1:0]   paddr        = '0;
  logic [PDATA_W-1:0]   pwdata       = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  text_window_tracker   tracker;
  bit                   calm         = 1'b0;
  int unsigned          cycle_count  = 0;
  int unsigned          sent_count   = 0;
  int unsigned          setting_count = 0;

  text_region_wrap_scroll DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest correct run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, tracker.window_replies.size());
    $display("Regression FAIL");
    $finish;
  end

  // Check each accepted result, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_result(result);
    result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offer one item, idling first at random, and note it once taken
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    tracker.note_item(it);
    sent_count++;
  endtask

  task automatic send(input cmd_t cmd, input logic [CHAR_W-1:0] code,
                      input logic [RROW_W-1:0] row, input logic [RCOL_W-1:0] col);
    in_item_t it;
    it.command   = cmd;
    it.char_code = code;
    it.read_row  = row;
    it.read_col  = col;
    send_item(it);
  endtask

  // Drop valid, drain every reply, then let a scroll in progress finish
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (tracker.window_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit is_write, input reg_idx_t idx,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= PADDR_W'(int'(idx) << REG_IDX_LSB);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register with junk in the unused bits, then read it back
  task automatic set_register(input reg_idx_t idx, input logic [7:0] value);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] readback;
    logic [PDATA_W-1:0] want;
    wdata      = $urandom;
    wdata[7:0] = value;
    want = (idx == REG_COLUMN_COUNT) ? PDATA_W'(wdata[COL_CFG_W-1:0])
                                     : PDATA_W'(wdata[ROW_CFG_W-1:0]);
    apb_access(1'b1, idx, wdata, readback);
    tracker.write_register(idx, wdata);
    apb_access(1'b0, idx, '0, readback);
    if (readback !== want)
      tracker.report($sformatf("register %s reads %h, want %h", idx.name(), readback, want));
  endtask

  task automatic set_window(input logic [7:0] cols, input logic [7:0] rows);
    wait_idle();
    set_register(REG_COLUMN_COUNT, cols);
    set_register(REG_ROW_COUNT, rows);
    setting_count++;
  endtask

  // Mostly puts with a fair share of newlines, reads aimed at the window edges
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned cols;
    int unsigned rows;
    it.command   = CMD_PUT;
    it.char_code = CHAR_W'($urandom_range(255));
    it.read_row  = RROW_W'($urandom_range(63));
    it.read_col  = RCOL_W'($urandom_range(127));
    cols = tracker.cols_in_use();
    rows = tracker.rows_in_use();
    pick = $urandom_range(999);
    if (pick < 3) begin
      it.command = CMD_CLEAR;
    end else if (pick < 33) begin
      it.command = CMD_NONE;
    end else if (pick < 330) begin
      it.command = CMD_READ;
      if ($urandom_range(3) != 0) begin
        it.read_row = RROW_W'($urandom_range((rows > 63) ? 63 : rows));
        it.read_col = RCOL_W'($urandom_range((cols > 127) ? 127 : cols));
      end
    end else if ($urandom_range(99) < 12) begin
      it.char_code = CODE_NEWLINE;
    end
    return it;
  endfunction

  initial begin
    logic [7:0] cols;
    logic [7:0] rows;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of bytes and cells at the default 80 x 24 window
    send(CMD_CLEAR, 8'h00, 6'd0, 7'd0);
    send(CMD_PUT, 8'h48, 6'd0, 7'd0);
    send(CMD_PUT, 8'h00, 6'd0, 7'd0);
    send(CMD_PUT, 8'hFF, 6'd63, 7'd127);
    send(CMD_READ, 8'h00, 6'd0, 7'd0);
    send(CMD_READ, 8'hFF, 6'd0, 7'd2);
    send(CMD_READ, 8'h00, 6'd0, 7'd3);
    send(CMD_PUT, CODE_NEWLINE, 6'd0, 7'd0);
    send(CMD_READ, 8'h00, 6'd23, 7'd79);
    send(CMD_READ, 8'h00, 6'd24, 7'd0);
    send(CMD_READ, 8'h00, 6'd0, 7'd80);
    send(CMD_READ, 8'h00, 6'd63, 7'd127);
    send(CMD_NONE, 8'hFF, 6'd63, 7'd127);

    // Zero registers act as a one-cell window: every wrap and newline scrolls
    set_window(8'd0, 8'd0);
    send(CMD_PUT, 8'h61, 6'd0, 7'd0);
    send(CMD_PUT, 8'h62, 6'd0, 7'd0);
    send(CMD_READ, 8'h00, 6'd0, 7'd0);
    send(CMD_PUT, CODE_NEWLINE, 6'd0, 7'd0);
    send(CMD_READ, 8'h00, 6'd0, 7'd0);
    send(CMD_READ, 8'h00, 6'd1, 7'd0);

    // Wrap onto the second row of a 3 x 2 window without scrolling
    set_window(8'd3, 8'd2);
    send(CMD_PUT, 8'h78, 6'd0, 7'd0);
    send(CMD_PUT, 8'h79, 6'd0, 7'd0);
    send(CMD_PUT, 8'h7A, 6'd0, 7'd0);
    send(CMD_PUT, 8'h77, 6'd0, 7'd0);
    send(CMD_READ, 8'h00, 6'd1, 7'd0);

    // Random phases; odd phases keep the old contents, so some shrink a window in use
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols = 8'd0;   rows = 8'd0;   end
        1: begin cols = 8'd1;   rows = 8'd1;   end
        2: begin cols = 8'd128; rows = 8'd64;  end
        3: begin cols = 8'd255; rows = 8'd127; end
        4: begin cols = 8'd80;  rows = 8'd24;  end
        5: begin cols = 8'd4;   rows = 8'd3;   end
        6: begin cols = 8'd129; rows = 8'd65;  end
        7: begin cols = 8'd7;   rows = 8'd2;   end
        default: begin
          cols = 8'($urandom_range(255));
          rows = 8'($urandom_range(127));
        end
      endcase
      set_window(cols, rows);
      calm = (p == 4);
      if (p % 2 == 0) send(CMD_CLEAR, CHAR_W'($urandom_range(255)),
                           RROW_W'($urandom_range(63)), RCOL_W'($urandom_range(127)));
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    calm = 1'b0;

    wait_idle();
    $display("Sent %0d items over %0d window settings, %0d clears; %0d results checked.",
             sent_count, setting_count, tracker.clear_count, tracker.checked_count);
    $display("Model saw %0d scrolls and %0d line wraps in %0d cycles.",
             tracker.scroll_count, tracker.wrap_count, cycle_count);
    if (tracker.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
